### hw/rtl/bdq_pkg.sv
// bdq_pkg: shared types and codes for the bounded double-ended queue.
// Used by bdq_front, bdq_back and bounded_double_ended_queue.
// No dependencies.
package bdq_pkg;

    // command codes on the cmd port
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_DUMP       = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // classified operation as carried from front to back
    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_DUMP,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] value;
    } op_beat_t;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic     valid;
        op_beat_t beat;
    } queue_head_t;

    typedef enum logic [1:0] {
        BK_EXEC,
        BK_DUMP,
        BK_DRAIN
    } back_state_t;

endpackage

### hw/rtl/bdq_ram.sv
// bdq_ram: generic single-write, single-read RAM with registered read data.
// Holds the ring store of the queue. No dependencies.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/bdq_front.sv
// bdq_front: accepts commands, classifies them and holds them in a
// two-entry queue for the back end. Depends on bdq_pkg.
module bdq_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           cmd,
    input  logic signed [31:0]   value,
    output bdq_pkg::queue_head_t head,
    input  logic                 take
);

    bdq_pkg::op_beat_t q_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              push;
    logic              pop;
    bdq_pkg::op_t      op_dec;

    always_comb
    begin
        unique case (cmd)
            bdq_pkg::CMD_PUSH_FRONT: op_dec = bdq_pkg::OP_PUSH_FRONT;
            bdq_pkg::CMD_PUSH_BACK:  op_dec = bdq_pkg::OP_PUSH_BACK;
            bdq_pkg::CMD_POP_FRONT:  op_dec = bdq_pkg::OP_POP_FRONT;
            bdq_pkg::CMD_POP_BACK:   op_dec = bdq_pkg::OP_POP_BACK;
            bdq_pkg::CMD_DUMP:       op_dec = bdq_pkg::OP_DUMP;
            default:                 op_dec = bdq_pkg::OP_NOP;
        endcase
    end

    assign busy = cnt_reg[1];
    assign push = start && !busy;
    assign pop  = take && (cnt_reg != 2'd0);

    assign head.valid = (cnt_reg != 2'd0);
    assign head.beat  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].op    <= op_dec;
            q_reg[wr_ptr_reg].value <= value;
        end
    end

endmodule

### hw/rtl/bdq_back.sv
// bdq_back: executes queued operations on the ring store and forms results.
// Depends on bdq_pkg and bdq_ram.
module bdq_back #(
    parameter int DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bdq_pkg::queue_head_t head,
    output logic                 take,
    output logic                 strobe,
    output logic [1:0]           status,
    output logic signed [31:0]   word,
    output logic                 last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 2;

    bdq_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] dump_ptr_reg, dump_ptr_next;
    logic [CW-1:0] dump_left_reg, dump_left_next;
    logic          res_valid_reg, res_valid_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic          res_last_reg, res_last_next;
    logic          res_ram_reg, res_ram_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [31:0]   ram_rdata;

    logic          full;
    logic          empty;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [AW-1:0] dump_inc;
    logic [SW-1:0] back_sum;
    logic [AW-1:0] back_idx;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign dump_inc  = (dump_ptr_reg == AW'(DEPTH - 1)) ? '0 : dump_ptr_reg + 1'b1;

    // front + count stays below twice the depth: one compare and subtract wraps it
    always_comb
    begin
        back_sum = SW'(front_reg) + SW'(count_reg);
        if (back_sum >= SW'(DEPTH))
        begin
            back_sum = back_sum - SW'(DEPTH);
        end
        back_idx = back_sum[AW-1:0];
    end

    assign take = (state_reg == bdq_pkg::BK_EXEC) && head.valid;

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        dump_ptr_next   = dump_ptr_reg;
        dump_left_next  = dump_left_reg;
        res_valid_next  = 1'b0;
        res_status_next = bdq_pkg::ST_OK;
        res_last_next   = 1'b1;
        res_ram_next    = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = front_dec;
        ram_wdata       = head.beat.value;
        ram_re          = 1'b0;

        unique case (state_reg)
            bdq_pkg::BK_EXEC:
            begin
                if (head.valid)
                begin
                    res_valid_next = 1'b1;
                    unique case (head.beat.op)
                        bdq_pkg::OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_status_next = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bdq_pkg::OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_status_next = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = back_idx;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bdq_pkg::OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_status_next = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                front_next = front_inc;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        bdq_pkg::OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_status_next = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        bdq_pkg::OP_DUMP:
                        begin
                            if (empty)
                            begin
                                res_status_next = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // beats come from the read loop instead
                                res_valid_next = 1'b0;
                                dump_ptr_next  = front_reg;
                                dump_left_next = count_reg;
                                state_next     = bdq_pkg::BK_DUMP;
                            end
                        end
                        default:
                        begin
                            res_status_next = bdq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            bdq_pkg::BK_DUMP:
            begin
                // read issued now, data lands with the result beat next cycle
                ram_re         = 1'b1;
                res_valid_next = 1'b1;
                res_ram_next   = 1'b1;
                res_last_next  = (dump_left_reg == CW'(1));
                dump_ptr_next  = dump_inc;
                dump_left_next = dump_left_reg - 1'b1;
                if (dump_left_reg == CW'(1))
                begin
                    state_next = bdq_pkg::BK_DRAIN;
                end
            end
            bdq_pkg::BK_DRAIN:
            begin
                // final dump beat is on the outputs; keep the result slot free
                state_next = bdq_pkg::BK_EXEC;
            end
            default:
            begin
                state_next = bdq_pkg::BK_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdq_pkg::BK_EXEC;
            front_reg     <= '0;
            count_reg     <= '0;
            dump_ptr_reg  <= '0;
            dump_left_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            dump_ptr_reg  <= dump_ptr_next;
            dump_left_reg <= dump_left_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        res_ram_reg    <= res_ram_next;
    end

    bdq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (dump_ptr_reg),
        .rdata (ram_rdata)
    );

    assign strobe = res_valid_reg;
    assign status = res_status_reg;
    assign last   = res_last_reg;
    assign word   = res_ram_reg ? $signed(ram_rdata) : 32'sd0;

endmodule

### hw/rtl/bounded_double_ended_queue.sv
// bounded_double_ended_queue: top level of the bounded deque of 32-bit words.
// Depends on bdq_pkg, bdq_front, bdq_back (and bdq_ram through bdq_back).
//
// Usage:
//   Command channel: drive cmd/value and raise start; the beat is taken at
//   a rising edge with start high and busy low. busy rises when the
//   two-entry command queue between front and back end is full.
//   Result channel: each result beat shows on status/word/last for exactly
//   one cycle with strobe high. The receiver cannot stall this channel.
//   Path: a push, pop or unused-code command passes the command queue,
//   then its result is registered; the first word of a dump also passes
//   the dump state and the registered ring-store read. Any wait in the
//   command queue comes on top. The back end takes a new push, pop or
//   unused code while in its exec state. A dump holds it: one ring-store
//   read per word on the single read port, then a drain state; a dump of
//   an empty queue returns one ST_EMPTY result and holds nothing.
//   Reset: rst_n low empties the queue and the command queue; stored words
//   are not cleared, only the front index and count.
module bounded_double_ended_queue #(
    parameter int DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          cmd,
    input  logic signed [31:0]  value,
    output logic                strobe,
    output logic [1:0]          status,
    output logic signed [31:0]  word,
    output logic                last
);

    bdq_pkg::queue_head_t head;
    logic                 take;

    bdq_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .value (value),
        .head  (head),
        .take  (take)
    );

    bdq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .take   (take),
        .strobe (strobe),
        .status (status),
        .word   (word),
        .last   (last)
    );

endmodule
